[hw/rtl/chkht_pkg.sv]
package chkht_pkg;

	localparam int DEF_BUCKETS = 128;
	localparam int DEF_WAYS    = 4;
	localparam int COORD_W     = 32;
	localparam int KEY_W       = 2 * COORD_W;
	localparam int HASH_W      = 32;
	localparam int HANDLE_W    = 9;
	localparam logic [HASH_W-1:0] HASH_MUL = 32'd5000;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_LOOKUP = 2'd1,
		KIND_REMOVE = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_PRESENT  = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef struct packed {
		status_t               status;
		logic [HANDLE_W-1:0]   handle;
		logic                  write;
	} match_res_t;

endpackage

[hw/rtl/chkht_bucket.sv]
module chkht_bucket #(
	parameter int BUCKETS = chkht_pkg::DEF_BUCKETS,
	localparam int BUCKET_W = $clog2(BUCKETS)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 load,
	input  logic signed [chkht_pkg::COORD_W-1:0] x_coord,
	input  logic signed [chkht_pkg::COORD_W-1:0] y_coord,
	output logic                                 done,
	output logic [BUCKET_W-1:0]                  bucket
);

	localparam int  HASH_W = chkht_pkg::HASH_W;
	localparam bit  POW2   = (BUCKETS & (BUCKETS - 1)) == 0;

	logic [HASH_W-1:0] hash_now;

	assign hash_now = HASH_W'($unsigned(x_coord))
		+ HASH_W'($unsigned(y_coord)) * chkht_pkg::HASH_MUL;

	if (POW2) begin : g_mask
		assign done   = load;
		assign bucket = hash_now[BUCKET_W-1:0];
	end else begin : g_recip
		localparam logic [HASH_W-1:0] RECIP   = HASH_W'((64'd1 << HASH_W) / 64'(BUCKETS));
		localparam logic [HASH_W-1:0] DIVISOR = HASH_W'(BUCKETS);

		logic                  v_s1;
		logic                  v_s2;
		logic                  v_s3;
		logic [HASH_W-1:0]     h_s1;
		logic [HASH_W-1:0]     h_s2;
		logic [2*HASH_W-1:0]   prod_s2;
		logic [BUCKET_W:0]     rem_s3;
		logic [HASH_W-1:0]     quot;
		logic [HASH_W-1:0]     rem_wide;

		// reciprocal quotient is low by at most one, one final subtract
		assign quot     = prod_s2[2*HASH_W-1:HASH_W];
		assign rem_wide = h_s2 - quot * DIVISOR;

		assign done   = v_s3;
		assign bucket = (rem_s3 >= (BUCKET_W+1)'(BUCKETS))
			? BUCKET_W'(rem_s3 - (BUCKET_W+1)'(BUCKETS)) : BUCKET_W'(rem_s3);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s1 <= 1'b0;
				v_s2 <= 1'b0;
				v_s3 <= 1'b0;
			end else begin
				v_s1 <= load;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
			end
		end

		always_ff @(posedge clk) begin
			if (load) begin
				h_s1 <= hash_now;
			end
			if (v_s1) begin
				h_s2    <= h_s1;
				prod_s2 <= (2*HASH_W)'(h_s1) * (2*HASH_W)'(RECIP);
			end
			if (v_s2) begin
				rem_s3 <= rem_wide[BUCKET_W:0];
			end
		end
	end

endmodule

[hw/rtl/chkht_match.sv]
module chkht_match #(
	parameter int BUCKETS = chkht_pkg::DEF_BUCKETS,
	parameter int WAYS    = chkht_pkg::DEF_WAYS,
	localparam int BUCKET_W = $clog2(BUCKETS),
	localparam int ROW_W    = WAYS * (chkht_pkg::KEY_W + 1)
) (
	input  logic [1:0]                    kind,
	input  logic [chkht_pkg::KEY_W-1:0]   key,
	input  logic [BUCKET_W-1:0]           bucket,
	input  logic [ROW_W-1:0]              row,
	output chkht_pkg::match_res_t         res,
	output logic [ROW_W-1:0]              new_row
);

	localparam int KEY_W  = chkht_pkg::KEY_W;
	localparam int KEYS_W = WAYS * KEY_W;
	localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int SLOT_W = $clog2(BUCKETS * WAYS);
	localparam int HW     = chkht_pkg::HANDLE_W;

	logic [WAYS-1:0]   vld;
	logic [WAYS-1:0]   eq;
	logic              hit;
	logic              have_free;
	logic [WAY_W-1:0]  hit_way;
	logic [WAY_W-1:0]  free_way;
	logic [WAY_W-1:0]  sel_way;
	logic [SLOT_W-1:0] slot;
	logic [SLOT_W+HW-1:0] slot_ext;

	always_comb begin
		hit       = 1'b0;
		have_free = 1'b0;
		hit_way   = '0;
		free_way  = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			vld[w] = row[KEYS_W + w];
			eq[w]  = vld[w] && (row[w*KEY_W +: KEY_W] == key);
			if (eq[w]) begin
				hit     = 1'b1;
				hit_way = WAY_W'(w);
			end
			if (!vld[w]) begin
				have_free = 1'b1;
				free_way  = WAY_W'(w);
			end
		end
	end

	always_comb begin
		sel_way = hit_way;
		new_row = row;
		res.write  = 1'b0;
		res.status = chkht_pkg::ST_NOTFOUND;
		case (kind)
			chkht_pkg::KIND_INSERT: begin
				sel_way = free_way;
				if (hit) begin
					res.status = chkht_pkg::ST_PRESENT;
				end else if (!have_free) begin
					res.status = chkht_pkg::ST_FULL;
				end else begin
					res.status = chkht_pkg::ST_OK;
					res.write  = 1'b1;
					new_row[KEYS_W + 32'(free_way)] = 1'b1;
					new_row[32'(free_way)*KEY_W +: KEY_W] = key;
				end
			end
			chkht_pkg::KIND_REMOVE: begin
				if (hit) begin
					res.status = chkht_pkg::ST_OK;
					res.write  = 1'b1;
					new_row[KEYS_W + 32'(hit_way)] = 1'b0;
				end
			end
			default: begin
				if (hit) begin
					res.status = chkht_pkg::ST_OK;
				end
			end
		endcase
		slot     = SLOT_W'(bucket) * SLOT_W'(WAYS) + SLOT_W'(sel_way);
		slot_ext = (SLOT_W+HW)'(slot);
		res.handle = (res.status == chkht_pkg::ST_OK) ? slot_ext[HW-1:0] : '0;
	end

endmodule

[hw/rtl/coordinate_keyed_hash_table.sv]
// path: the start transfer goes straight to the compare state when BUCKETS is a
// power of two, else via S_MOD (remainder by reciprocal multiply, three stages)
// requests: one at a time, busy stays high until done
// reset: after arst_n releases, busy holds while a clearing pass empties every
// bucket row of the table memory
// results are strobed on done for one cycle; the receiver cannot stall
module coordinate_keyed_hash_table #(
	parameter int BUCKETS = chkht_pkg::DEF_BUCKETS,
	parameter int WAYS    = chkht_pkg::DEF_WAYS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [1:0]                            kind,
	input  logic signed [chkht_pkg::COORD_W-1:0]  x_coord,
	input  logic signed [chkht_pkg::COORD_W-1:0]  y_coord,
	output logic                                  done,
	output logic [1:0]                            status,
	output logic [chkht_pkg::HANDLE_W-1:0]        handle
);

	localparam int BUCKET_W = $clog2(BUCKETS);
	localparam int KEY_W    = chkht_pkg::KEY_W;
	localparam int ROW_W    = WAYS * (KEY_W + 1);

	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_IDLE  = 4'b0010,
		S_MOD   = 4'b0100,
		S_CMP   = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	logic [ROW_W-1:0]    mem [BUCKETS];
	logic [ROW_W-1:0]    rd_row_q;
	logic [BUCKET_W-1:0] clr_cnt_q;
	logic [BUCKET_W-1:0] bucket_q;
	logic [1:0]          kind_q;
	logic [KEY_W-1:0]    key_q;
	logic                done_q;
	logic [1:0]          status_q;
	logic [chkht_pkg::HANDLE_W-1:0] handle_q;

	logic                accept;
	logic                bu_done;
	logic [BUCKET_W-1:0] bu_bucket;
	logic                mem_we;
	logic [BUCKET_W-1:0] wr_addr;
	logic [ROW_W-1:0]    wr_row;
	logic [ROW_W-1:0]    new_row;
	chkht_pkg::match_res_t res;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	chkht_bucket #(
		.BUCKETS(BUCKETS)
	) u_bucket (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (accept),
		.x_coord (x_coord),
		.y_coord (y_coord),
		.done    (bu_done),
		.bucket  (bu_bucket)
	);

	chkht_match #(
		.BUCKETS(BUCKETS),
		.WAYS   (WAYS)
	) u_match (
		.kind    (kind_q),
		.key     (key_q),
		.bucket  (bucket_q),
		.row     (rd_row_q),
		.res     (res),
		.new_row (new_row)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_cnt_q == BUCKET_W'(BUCKETS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					state_d = bu_done ? S_CMP : S_MOD;
				end
			end
			S_MOD: begin
				if (bu_done) begin
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_comb begin
		mem_we  = 1'b0;
		wr_addr = bucket_q;
		wr_row  = new_row;
		if (state_q == S_CLEAR) begin
			mem_we  = 1'b1;
			wr_addr = clr_cnt_q;
			wr_row  = '0;
		end else if (state_q == S_CMP) begin
			mem_we = res.write;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_cnt_q <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_CMP);
			if (state_q == S_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + BUCKET_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			key_q  <= {y_coord, x_coord};
		end
		if (bu_done) begin
			bucket_q <= bu_bucket;
		end
		if (state_q == S_CMP) begin
			status_q <= res.status;
			handle_q <= res.handle;
		end
	end

	// table memory, read-modify-write of one bucket row
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_row;
		end
		if (bu_done) begin
			rd_row_q <= mem[bu_bucket];
		end
	end

	assign done   = done_q;
	assign status = status_q;
	assign handle = handle_q;

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("done strobe longer than one cycle");

	a_cmp_then_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |=> done_q)
		else $error("compare cycle without result");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_CMP || state_q == S_MOD))
		else $error("accepted request not started");

	a_handle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q != chkht_pkg::ST_OK) |-> (handle_q == '0))
		else $error("nonzero handle with error status");

	a_write_window: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_CMP || state_q == S_CLEAR))
		else $error("table write outside compare or clear");

endmodule
